// File: rtl/tsuw_pkg.sv
`timescale 1ns / 1ps
package tsuw_pkg;

  localparam int MAX_DIMENSION = 1024;

  localparam int DIM_W   = 11;
  localparam int OFS_W   = 12;
  localparam int FMT_W   = 4;
  localparam int PIX_W   = 32;
  localparam int IDX_W   = 20;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT  = 3'd6;

  localparam logic [FMT_W-1:0] FMT_RGBA8  = 4'd0;
  localparam logic [FMT_W-1:0] FMT_BGRA8  = 4'd1;
  localparam logic [FMT_W-1:0] FMT_RGB8   = 4'd2;
  localparam logic [FMT_W-1:0] FMT_BGR8   = 4'd3;
  localparam logic [FMT_W-1:0] FMT_L8     = 4'd4;
  localparam logic [FMT_W-1:0] FMT_LA8    = 4'd5;
  localparam logic [FMT_W-1:0] FMT_A8     = 4'd6;
  localparam logic [FMT_W-1:0] FMT_RGB565 = 4'd7;
  localparam logic [FMT_W-1:0] FMT_RAW32  = 4'd8;

  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [OFS_W-1:0] ofs_t;

endpackage

// File: rtl/tsuw_ifs.sv
`timescale 1ns / 1ps
interface tsuw_in_if import tsuw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] raw_pixel;
  logic             start_of_image;

  modport source (output valid, output raw_pixel, output start_of_image, input ready);
  modport sink   (input valid, input raw_pixel, input start_of_image, output ready);
endinterface

interface tsuw_out_if import tsuw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] argb_pixel;
  logic [IDX_W-1:0] dest_index;
  logic             write_enable;

  modport source (output valid, output argb_pixel, output dest_index, output write_enable,
                  input ready);
  modport sink   (input valid, input argb_pixel, input dest_index, input write_enable,
                  output ready);
endinterface

// File: rtl/texture_subimage_unpack_writer.sv
`timescale 1ns / 1ps
// Sub-image pixel writer: takes one source pixel per item in raster order, unpacks it from
// the configured format to ARGB8888 and returns one result per item with the linear
// destination index (row times dest_width plus column, after the signed offsets) and a write
// enable that is low for pixels clipped by the texture bounds or past the last source row.
// The unpack, the clip compares and the index multiply-add are combinational and sit
// between the input handshake and a single output register, and a new item is taken every
// cycle while the output register is empty or being drained. Column and row counters restart
// on start_of_image; dimensions above MAX_DIMENSION are saturated. Configuration writes take
// effect from the next item.
module texture_subimage_unpack_writer import tsuw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tsuw_in_if.sink               in_ch,
  tsuw_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam dim_t MAX_DIM = DIM_W'(MAX_DIMENSION);

  dim_t             dest_width_r, dest_height_r, source_width_r, source_height_r;
  ofs_t             offset_x_r, offset_y_r;
  logic [FMT_W-1:0] pixel_format_r;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic             out_valid_r;
  logic [PIX_W-1:0] argb_r, argb_nxt;
  logic [IDX_W-1:0] index_r, index_nxt;
  logic             we_r, we_nxt;

  logic             in_fire;
  dim_t             dw, dh, sw, sh;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic signed [OFS_W:0] dx, dy;
  logic [DIM_W:0]   col_inc;
  logic [7:0]       b0, b1, b2, b3, r565, g565, b565;
  logic [IDX_W-1:0] prod;

  function automatic dim_t sat_dim(input dim_t v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

  // floor(v * 255 / 31) = 8v + floor(7v / 31)
  function automatic logic [7:0] scale5(input logic [4:0] v);
    logic [2:0] c;
    c = 3'(v >= 5'd5) + 3'(v >= 5'd9) + 3'(v >= 5'd14) + 3'(v >= 5'd18)
      + 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v >= 5'd31);
    return {v, 3'b000} + {5'd0, c};
  endfunction

  // floor(v * 255 / 63) = 4v + floor(v / 21)
  function automatic logic [7:0] scale6(input logic [5:0] v);
    logic [1:0] c;
    c = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
    return {v, 2'b00} + {6'd0, c};
  endfunction

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid_r || out_ch.ready;

  assign dw = sat_dim(dest_width_r);
  assign dh = sat_dim(dest_height_r);
  assign sh = sat_dim(source_height_r);
  assign sw = (source_width_r == '0) ? DIM_W'(1) : sat_dim(source_width_r);

  assign col_cur = in_ch.start_of_image ? '0 : col_r;
  assign row_cur = in_ch.start_of_image ? '0 : row_r;

  assign dx = $signed({offset_x_r[OFS_W-1], offset_x_r})
            + $signed({{(OFS_W+1-COL_W){1'b0}}, col_cur});
  assign dy = $signed({offset_y_r[OFS_W-1], offset_y_r})
            + $signed({{(OFS_W+1-ROW_W){1'b0}}, row_cur});

  assign b0 = in_ch.raw_pixel[7:0];
  assign b1 = in_ch.raw_pixel[15:8];
  assign b2 = in_ch.raw_pixel[23:16];
  assign b3 = in_ch.raw_pixel[31:24];
  assign r565 = scale5(in_ch.raw_pixel[15:11]);
  assign g565 = scale6(in_ch.raw_pixel[10:5]);
  assign b565 = scale5(in_ch.raw_pixel[4:0]);

  always_comb begin
    case (pixel_format_r)
      FMT_RGBA8:  argb_nxt = {b3, b0, b1, b2};
      FMT_BGRA8:  argb_nxt = {b3, b2, b1, b0};
      FMT_RGB8:   argb_nxt = {8'hFF, b0, b1, b2};
      FMT_BGR8:   argb_nxt = {8'hFF, b2, b1, b0};
      FMT_L8:     argb_nxt = {8'hFF, b0, b0, b0};
      FMT_LA8:    argb_nxt = {b1, b0, b0, b0};
      FMT_A8:     argb_nxt = {b0, 24'hFFFFFF};
      FMT_RGB565: argb_nxt = {8'hFF, r565, g565, b565};
      FMT_RAW32:  argb_nxt = in_ch.raw_pixel;
      default:    argb_nxt = 32'hFFFFFFFF;
    endcase
  end

  always_comb begin
    we_nxt = (row_cur < sh) && !dx[OFS_W] && (dx[OFS_W-1:0] < {1'b0, dw})
          && !dy[OFS_W] && (dy[OFS_W-1:0] < {1'b0, dh});
    // inside the texture both coordinates stay below MAX_DIMENSION
    prod = IDX_W'(dy[COL_W-1:0]) * IDX_W'(dw) + IDX_W'(dx[COL_W-1:0]);
    index_nxt = we_nxt ? prod : '0;
  end

  always_comb begin
    col_inc = {{(DIM_W+1-COL_W){1'b0}}, col_cur} + (DIM_W+1)'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (col_inc >= {1'b0, sw}) begin
        col_nxt = '0;
        row_nxt = (row_cur < sh) ? row_cur + ROW_W'(1) : row_cur;
      end else begin
        col_nxt = col_inc[COL_W-1:0];
        row_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_width_r    <= DIM_W'(1);
      dest_height_r   <= DIM_W'(1);
      offset_x_r      <= '0;
      offset_y_r      <= '0;
      source_width_r  <= DIM_W'(1);
      source_height_r <= DIM_W'(1);
      pixel_format_r  <= FMT_RGBA8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEST_WIDTH:    dest_width_r    <= cfg_wdata[DIM_W-1:0];
        CFG_DEST_HEIGHT:   dest_height_r   <= cfg_wdata[DIM_W-1:0];
        CFG_OFFSET_X:      offset_x_r      <= cfg_wdata[OFS_W-1:0];
        CFG_OFFSET_Y:      offset_y_r      <= cfg_wdata[OFS_W-1:0];
        CFG_SOURCE_WIDTH:  source_width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_SOURCE_HEIGHT: source_height_r <= cfg_wdata[DIM_W-1:0];
        CFG_PIXEL_FORMAT:  pixel_format_r  <= cfg_wdata[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      argb_r  <= argb_nxt;
      index_r <= index_nxt;
      we_r    <= we_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.argb_pixel   = argb_r;
  assign out_ch.dest_index   = index_r;
  assign out_ch.write_enable = we_r;

`ifndef SYNTHESIS
  a_row_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= ROW_W'(MAX_DIMENSION))
    else $error("row counter beyond max dimension");

  a_clipped_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !we_r |-> index_r == '0)
    else $error("clipped item carries nonzero index");

  a_accept_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted item did not reach output register");

  a_stall_holds_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(col_r) && $stable(row_r))
    else $error("counters moved without an accepted item");
`endif

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import tsuw_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 24;
  localparam int PHASE_PIXELS = 48;

  typedef struct packed {
    logic [PIX_W-1:0] argb;
    logic [IDX_W-1:0] index;
    logic             wr_en;
  } texel_write_t;

  typedef struct {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_sel;
    logic [PIX_W-1:0]      value;
    logic                  soi;
    logic                  pinned;
    texel_write_t          want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tsuw_in_if  in_ch ();
  tsuw_out_if out_ch ();

  texture_subimage_unpack_writer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow registers and raster counters
  logic [DIM_W-1:0] reg_dest_w, reg_dest_h, reg_src_w, reg_src_h;
  logic [OFS_W-1:0] reg_ofs_x, reg_ofs_y;
  logic [FMT_W-1:0] reg_fmt;
  int col_pos, row_pos;

  texel_write_t expected_writes[$];
  plan_row_t directed_plan[$];

  logic         pin_on;
  texel_write_t pin_want;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int pixels_sent = 0;
  int results_checked = 0;
  int writes_enabled = 0;
  int settings_used = 0;
  int cycle_count = 0;

  function automatic int clamp_dim(logic [DIM_W-1:0] v);
    return (int'(v) > MAX_DIMENSION) ? MAX_DIMENSION : int'(v);
  endfunction

  function automatic logic [PIX_W-1:0] unpack_to_argb(logic [PIX_W-1:0] raw,
                                                      logic [FMT_W-1:0] fmt);
    int unsigned r, g, b;
    r = 32'(raw[15:11]) * 255 / 31;
    g = 32'(raw[10:5]) * 255 / 63;
    b = 32'(raw[4:0]) * 255 / 31;
    case (fmt)
      FMT_RGBA8:  return {raw[31:24], raw[7:0], raw[15:8], raw[23:16]};
      FMT_BGRA8:  return {raw[31:24], raw[23:16], raw[15:8], raw[7:0]};
      FMT_RGB8:   return {8'hFF, raw[7:0], raw[15:8], raw[23:16]};
      FMT_BGR8:   return {8'hFF, raw[23:16], raw[15:8], raw[7:0]};
      FMT_L8:     return {8'hFF, {3{raw[7:0]}}};
      FMT_LA8:    return {raw[15:8], {3{raw[7:0]}}};
      FMT_A8:     return {raw[7:0], 24'hFF_FFFF};
      FMT_RGB565: return {8'hFF, r[7:0], g[7:0], b[7:0]};
      FMT_RAW32:  return raw;
      default:    return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic texel_write_t predict_texel_write(logic [PIX_W-1:0] raw, logic soi);
    texel_write_t t;
    int dw, dh, sw, sh, dx, dy;
    dw = clamp_dim(reg_dest_w);
    dh = clamp_dim(reg_dest_h);
    sw = clamp_dim(reg_src_w);
    sh = clamp_dim(reg_src_h);
    if (sw == 0) begin
      sw = 1;
    end
    if (soi) begin
      col_pos = 0;
      row_pos = 0;
    end
    dx = int'($signed(reg_ofs_x)) + col_pos;
    dy = int'($signed(reg_ofs_y)) + row_pos;
    t.argb = unpack_to_argb(raw, reg_fmt);
    t.wr_en = (row_pos < sh) && (dx >= 0) && (dx < dw) && (dy >= 0) && (dy < dh);
    t.index = t.wr_en ? IDX_W'(dy * dw + dx) : '0;
    if (col_pos + 1 >= sw) begin
      col_pos = 0;
      if (row_pos < sh) begin
        row_pos = row_pos + 1;
      end
    end else begin
      col_pos = col_pos + 1;
    end
    return t;
  endfunction

  function automatic void plan_cfg(logic [CFG_IDX_W-1:0] sel, logic [PIX_W-1:0] val);
    plan_row_t p;
    p = '{1'b1, sel, val, 1'b0, 1'b0, '0};
    directed_plan.push_back(p);
  endfunction

  function automatic void plan_pixel(logic [PIX_W-1:0] raw, logic soi, logic pinned,
                                     logic [PIX_W-1:0] argb, logic [IDX_W-1:0] idx,
                                     logic we);
    plan_row_t p;
    p = '{1'b0, CFG_DEST_WIDTH, raw, soi, pinned, '{argb, idx, we}};
    directed_plan.push_back(p);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    case (sel)
      CFG_DEST_WIDTH:    reg_dest_w = val[DIM_W-1:0];
      CFG_DEST_HEIGHT:   reg_dest_h = val[DIM_W-1:0];
      CFG_OFFSET_X:      reg_ofs_x = val[OFS_W-1:0];
      CFG_OFFSET_Y:      reg_ofs_y = val[OFS_W-1:0];
      CFG_SOURCE_WIDTH:  reg_src_w = val[DIM_W-1:0];
      CFG_SOURCE_HEIGHT: reg_src_h = val[DIM_W-1:0];
      CFG_PIXEL_FORMAT:  reg_fmt = val[FMT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] raw, logic soi, logic pinned,
                            texel_write_t want);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.raw_pixel <= raw;
    in_ch.start_of_image <= soi;
    pin_on <= pinned;
    pin_want <= want;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_pixels();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_writes.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // result receiver
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    texel_write_t got, want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        want = predict_texel_write(in_ch.raw_pixel, in_ch.start_of_image);
        if (pin_on) begin
          want = pin_want;
        end
        expected_writes.push_back(want);
        pixels_sent++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.argb_pixel, out_ch.dest_index, out_ch.write_enable};
        if (expected_writes.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("unexpected item: argb %h index %h we %b", got.argb, got.index,
                     got.wr_en);
          end
        end else begin
          want = expected_writes.pop_front();
          results_checked++;
          if (want.wr_en) begin
            writes_enabled++;
          end
          if (got !== want) begin
            error_count++;
            if (error_count <= 10) begin
              $display("mismatch at item %0d: argb %h/%h index %h/%h we %b/%b (exp/act)",
                       results_checked, want.argb, got.argb, want.index, got.index,
                       want.wr_en, got.wr_en);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items outstanding", cycle_count,
               expected_writes.size());
      $display("texture_subimage_unpack_writer verification failed");
      $finish;
    end
  end

  initial begin
    int phase, kind, sent, img_len, ew, eh, k;
    logic writing, broken, soi;
    logic [DIM_W-1:0] dw, dh, sw, sh;
    logic [OFS_W-1:0] ox, oy;
    logic [FMT_W-1:0] fmt;

    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_DEST_WIDTH;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.raw_pixel <= '0;
    in_ch.start_of_image <= 1'b0;
    pin_on <= 1'b0;
    pin_want <= '0;
    reg_dest_w = 1;
    reg_dest_h = 1;
    reg_src_w = 1;
    reg_src_h = 1;
    reg_ofs_x = '0;
    reg_ofs_y = '0;
    reg_fmt = FMT_RGBA8;
    col_pos = 0;
    row_pos = 0;

    // after reset: 1x1 texture, one source row
    plan_pixel(32'h4433_2211, 1'b1, 1'b1, 32'h4411_2233, '0, 1'b1);
    plan_pixel(32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, '0, 1'b0);
    plan_pixel(32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, '0, 1'b0);
    plan_pixel(32'h8000_0001, 1'b1, 1'b1, 32'h8001_0000, '0, 1'b1);
    // every format
    plan_cfg(CFG_PIXEL_FORMAT, FMT_BGRA8);
    plan_pixel(32'h4433_2211, 1'b1, 1'b1, 32'h4433_2211, '0, 1'b1);
    plan_cfg(CFG_PIXEL_FORMAT, FMT_RGB8);
    plan_pixel(32'h4433_2211, 1'b1, 1'b1, 32'hFF11_2233, '0, 1'b1);
    plan_cfg(CFG_PIXEL_FORMAT, FMT_BGR8);
    plan_pixel(32'h4433_2211, 1'b1, 1'b1, 32'hFF33_2211, '0, 1'b1);
    plan_cfg(CFG_PIXEL_FORMAT, FMT_L8);
    plan_pixel(32'h4433_2211, 1'b1, 1'b1, 32'hFF11_1111, '0, 1'b1);
    plan_cfg(CFG_PIXEL_FORMAT, FMT_LA8);
    plan_pixel(32'h4433_2211, 1'b1, 1'b1, 32'h2211_1111, '0, 1'b1);
    plan_cfg(CFG_PIXEL_FORMAT, FMT_A8);
    plan_pixel(32'h4433_2211, 1'b1, 1'b1, 32'h11FF_FFFF, '0, 1'b1);
    plan_cfg(CFG_PIXEL_FORMAT, FMT_RGB565);
    plan_pixel(32'h0000_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, '0, 1'b1);
    plan_pixel(32'hABCD_0000, 1'b1, 1'b1, 32'hFF00_0000, '0, 1'b1);
    plan_pixel(32'h0000_8410, 1'b1, 1'b0, '0, '0, 1'b0);
    plan_cfg(CFG_PIXEL_FORMAT, FMT_RAW32);
    plan_pixel(32'hDEAD_BEEF, 1'b1, 1'b1, 32'hDEAD_BEEF, '0, 1'b1);
    plan_cfg(CFG_PIXEL_FORMAT, FMT_RAW32 + 1);
    plan_pixel(32'h1234_5678, 1'b1, 1'b1, 32'hFFFF_FFFF, '0, 1'b1);
    plan_cfg(CFG_PIXEL_FORMAT, 4'hF);
    plan_pixel(32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, '0, 1'b1);
    // oversized sizes, offset extremes, far corner
    plan_cfg(CFG_PIXEL_FORMAT, FMT_RAW32);
    plan_cfg(CFG_DEST_WIDTH, 2047);
    plan_cfg(CFG_DEST_HEIGHT, 2047);
    plan_cfg(CFG_SOURCE_WIDTH, 2047);
    plan_cfg(CFG_SOURCE_HEIGHT, 2047);
    plan_cfg(CFG_OFFSET_X, 12'h7FF);
    plan_pixel(32'h1234_5678, 1'b1, 1'b1, 32'h1234_5678, '0, 1'b0);
    plan_cfg(CFG_OFFSET_X, 12'h800);
    plan_pixel(32'h8765_4321, 1'b1, 1'b1, 32'h8765_4321, '0, 1'b0);
    plan_cfg(CFG_OFFSET_X, 1023);
    plan_cfg(CFG_OFFSET_Y, 1023);
    plan_pixel(32'hCAFE_F00D, 1'b1, 1'b1, 32'hCAFE_F00D, 20'hF_FFFF, 1'b1);
    // zero sizes
    plan_cfg(CFG_OFFSET_X, 0);
    plan_cfg(CFG_OFFSET_Y, 0);
    plan_cfg(CFG_DEST_WIDTH, 0);
    plan_pixel(32'h5555_AAAA, 1'b1, 1'b1, 32'h5555_AAAA, '0, 1'b0);
    plan_cfg(CFG_DEST_WIDTH, 5);
    plan_cfg(CFG_DEST_HEIGHT, 3);
    plan_cfg(CFG_SOURCE_WIDTH, 0);
    plan_cfg(CFG_SOURCE_HEIGHT, 3);
    plan_cfg(CFG_OFFSET_X, 1);
    plan_pixel(32'h0102_0304, 1'b1, 1'b0, '0, '0, 1'b0);
    plan_pixel(32'hA0B0_C0D0, 1'b0, 1'b0, '0, '0, 1'b0);
    plan_pixel(32'h7F80_01FE, 1'b0, 1'b0, '0, '0, 1'b0);
    plan_pixel(32'hFEDC_BA98, 1'b0, 1'b0, '0, '0, 1'b0);
    plan_cfg(CFG_SOURCE_HEIGHT, 0);
    plan_pixel(32'h3C3C_C3C3, 1'b1, 1'b1, 32'h3C3C_C3C3, '0, 1'b0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    writing = 1'b0;
    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        if (!writing) begin
          drain_pixels();
        end
        write_reg(directed_plan[i].reg_sel, directed_plan[i].value[CFG_DATA_W-1:0]);
        writing = 1'b1;
      end else begin
        if (writing) begin
          cfg_we <= 1'b0;
        end
        writing = 1'b0;
        send_pixel(directed_plan[i].value, directed_plan[i].soi, directed_plan[i].pinned,
                   directed_plan[i].want);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      drain_pixels();
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 62; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 62; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      kind = phase % 10;
      dw = DIM_W'($urandom_range(1, 16));
      dh = DIM_W'($urandom_range(1, 12));
      ox = OFS_W'(int'($urandom_range(0, 24)) - 8);
      oy = OFS_W'(int'($urandom_range(0, 16)) - 6);
      sw = DIM_W'($urandom_range(1, 10));
      sh = DIM_W'($urandom_range(1, 6));
      case (kind)
        6: begin
          ox = $urandom_range(0, 1) ? 12'h800 : 12'h7FF;
          oy = $urandom_range(0, 1) ? 12'hFFF : OFS_W'($urandom_range(0, 4));
        end
        7: begin
          dw = $urandom_range(0, 1) ? DIM_W'(MAX_DIMENSION) : DIM_W'($urandom_range(1025, 2047));
          dh = $urandom_range(0, 1) ? DIM_W'(MAX_DIMENSION) : DIM_W'($urandom_range(1025, 2047));
          ox = OFS_W'(MAX_DIMENSION - int'($urandom_range(1, 6)));
          oy = OFS_W'(MAX_DIMENSION - 1 - int'($urandom_range(0, 2)));
          sw = DIM_W'($urandom_range(1, 8));
          sh = DIM_W'($urandom_range(1, 4));
        end
        8: begin
          case ($urandom_range(0, 3))
            0: dw = '0;
            1: dh = '0;
            2: sh = '0;
            default: sw = '0;
          endcase
        end
        9: begin
          dw = DIM_W'($urandom_range(0, 2047));
          dh = DIM_W'($urandom_range(0, 2047));
          ox = OFS_W'($urandom_range(0, 4095));
          oy = OFS_W'($urandom_range(0, 4095));
          sw = DIM_W'($urandom_range(0, 2047));
          sh = DIM_W'($urandom_range(0, 2047));
        end
        default: ;
      endcase
      fmt = (phase < 16) ? FMT_W'(phase) : FMT_W'($urandom_range(0, 15));
      write_reg(CFG_DEST_WIDTH, CFG_DATA_W'(dw));
      write_reg(CFG_DEST_HEIGHT, CFG_DATA_W'(dh));
      write_reg(CFG_OFFSET_X, CFG_DATA_W'(ox));
      write_reg(CFG_OFFSET_Y, CFG_DATA_W'(oy));
      write_reg(CFG_SOURCE_WIDTH, CFG_DATA_W'(sw));
      write_reg(CFG_SOURCE_HEIGHT, CFG_DATA_W'(sh));
      write_reg(CFG_PIXEL_FORMAT, CFG_DATA_W'(fmt));
      cfg_we <= 1'b0;
      settings_used++;

      ew = clamp_dim(sw);
      if (ew == 0) begin
        ew = 1;
      end
      eh = clamp_dim(sh);
      sent = 0;
      while (sent < PHASE_PIXELS) begin
        img_len = ew * eh + int'($urandom_range(0, 3));
        if (img_len > 80) begin
          img_len = $urandom_range(1, 80);
        end
        if (img_len == 0) begin
          img_len = 1;
        end
        broken = ($urandom_range(0, 7) == 0);
        for (k = 0; k < img_len; k++) begin
          if (broken) begin
            soi = (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0);
          end else begin
            soi = (k == 0);
          end
          send_pixel($urandom, soi, 1'b0, '0);
        end
        sent += img_len;
      end
    end

    drain_pixels();
    $display("%0d pixels over %0d register settings, %0d results checked, %0d write-enabled",
             pixels_sent, settings_used, results_checked, writes_enabled);
    $display("all formats, clipped edges, saturated and zero sizes, rows past the source; "
             , "%0d mismatches", error_count);
    if (error_count == 0 && expected_writes.size() == 0) begin
      $display("texture_subimage_unpack_writer verification clean");
    end else begin
      $display("texture_subimage_unpack_writer verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tsuw_pkg.sv
rtl/tsuw_ifs.sv
rtl/texture_subimage_unpack_writer.sv
sim/testbench.sv
